// ===== design/b32hd_pkg.sv =====
// Shared types, constants and the character lookup of the base32hex decoder.
package b32hd_pkg;

   localparam int CharWidth   = 8;
   localparam int SymWidth    = 5;
   localparam int ByteWidth   = 8;
   localparam int CountWidth  = 4;
   localparam int PendWidth   = 3;
   localparam int AccWidth    = 7;
   localparam int WideWidth   = AccWidth + SymWidth;
   localparam int RspDataWidth = 16;

   localparam int DefStringChars = 20;
   localparam int DefMaxBytes    = 12;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_CHAR  = 2'd1,
      STATUS_BAD_LEN   = 2'd2
   } status_type;

   typedef enum logic {
      KIND_DATA = 1'b0,
      KIND_END  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [ByteWidth-1:0]   byte_value;
      status_type             status;
      logic [CountWidth-1:0]  byte_count;
      logic                   end_of_run;
   } result_type;

   typedef struct packed {
      logic                 valid;
      logic [SymWidth-1:0]  value;
   } symbol_type;

   // Case-insensitive base32hex lookup: '0'-'9' give 0-9, 'a'-'v' and 'A'-'V' give 10-31.
   function automatic symbol_type symbol_lookup(input logic [CharWidth-1:0] ch);
      symbol_type sym;
      sym.valid = 1'b1;
      sym.value = '0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         sym.value = SymWidth'(ch - 8'h30);
      end else if (ch >= 8'h61 && ch <= 8'h76) begin
         sym.value = SymWidth'(ch - 8'h61 + 8'd10);
      end else if (ch >= 8'h41 && ch <= 8'h56) begin
         sym.value = SymWidth'(ch - 8'h41 + 8'd10);
      end else begin
         sym.valid = 1'b0;
      end
      return sym;
   endfunction

endpackage

// ===== design/base32hex_fixed_decoder_unit.sv =====
// Top level of the streaming base32hex string decoder with its result queue.

// The block takes one ASCII character per transfer and decodes a fixed-length base32hex
// string (STRING_CHARS characters, case-insensitive 0-9 and a-v). Every completed byte leaves
// as a data item (rsp_tuser low), and the character flagged by req_tlast produces an end item
// (rsp_tuser high) that carries the status (ok, invalid character, wrong length) and the byte
// count, which is zero on error. Wrong length wins over an invalid character, and after an
// invalid character the rest of the string is only counted. Downstream should drop the data
// bytes of a string whose status is not ok. A character is decoded in the cycle it is taken,
// so one transfer per clock is sustained; its results are written into a four-entry queue at
// the accepting edge; if the queue was empty, the first is offered on the result side in the next cycle.
// The only limit on the rate is that queue: the input is taken while at least two slots are
// free, since a last character can yield two results. The first character of a string yields
// at most an end item, so with a result side that is always ready the queue holds at most two
// entries and the input never stalls; only a result side that takes less than one transfer
// per cycle throttles the input. After reset the block is ready at once; there is no
// clearing pass.
module base32hex_fixed_decoder_unit
   import b32hd_pkg::*;
#(
   parameter int STRING_CHARS = DefStringChars,
   parameter int MAX_BYTES    = DefMaxBytes
) (
   input  logic                     clock,
   input  logic                     reset,
   // Input characters.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [CharWidth-1:0]     req_tdata,   // [7:0] char_code
   input  logic                     req_tlast,   // last_char
   // Results.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RspDataWidth-1:0]  rsp_tdata,   // [7:0] byte_value, [9:8] status,
                                                 // [13:10] byte_count, [15:14] zero
   output logic                     rsp_tuser,   // item_kind
   output logic                     rsp_tlast    // end_of_run
);

   // The character counter saturates one past the string length.
   localparam int SeenWidth = $clog2(STRING_CHARS + 2);
   localparam logic [SeenWidth-1:0] SeenFull = SeenWidth'(STRING_CHARS);
   localparam logic [SeenWidth-1:0] SeenSat  = SeenWidth'(STRING_CHARS + 1);
   localparam logic [CountWidth-1:0] ByteLimit = CountWidth'(MAX_BYTES);

   localparam int QueueDepth = 4;
   localparam int PtrWidth   = $clog2(QueueDepth);
   localparam int QCntWidth  = $clog2(QueueDepth + 1);
   localparam logic [QCntWidth-1:0] QueueRoomMax = QCntWidth'(QueueDepth - 2);

   // Decoder state.
   logic [AccWidth-1:0]    acc_ff, acc_in;
   logic [PendWidth-1:0]   pend_ff, pend_in;
   logic [SeenWidth-1:0]   seen_ff, seen_in;
   logic [CountWidth-1:0]  bytes_ff, bytes_in;
   logic                   bad_ff, bad_in;

   // Result queue.
   result_type             queue_ff [QueueDepth];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCntWidth-1:0]   qcnt_ff, qcnt_in;

   logic                   req_take;
   logic                   rsp_take;
   symbol_type             sym;
   logic [SeenWidth-1:0]   seen_step;
   logic                   decode_en;
   logic                   emit;
   logic [CountWidth-1:0]  total;
   logic [PendWidth-1:0]   rest;
   logic [WideWidth-1:0]   wide;
   logic [WideWidth-1:0]   rest_mask;
   logic                   bad_step;
   logic [CountWidth-1:0]  bytes_step;
   result_type             data_res;
   result_type             end_res;
   result_type             first_res;
   logic [1:0]             push_cnt;

   assign req_take = req_tvalid && req_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;

   // Two free slots are needed, since a last character can yield two results.
   assign req_tready = (qcnt_ff <= QueueRoomMax);

   // Decode path: lookup, accumulate, extract the completed byte and build the end item.
   always_comb begin
      sym        = symbol_lookup(req_tdata);
      seen_step  = (seen_ff < SeenSat) ? seen_ff + 1'b1 : seen_ff;
      decode_en  = !bad_ff && (seen_step <= SeenFull);
      bad_step   = bad_ff || (decode_en && !sym.valid);
      total      = CountWidth'(pend_ff) + CountWidth'(SymWidth);
      rest       = PendWidth'(total - CountWidth'(ByteWidth));
      wide       = {acc_ff, sym.value};
      rest_mask  = (WideWidth'(1) << rest) - WideWidth'(1);
      emit       = decode_en && sym.valid && (bytes_ff < ByteLimit) &&
                   (total >= CountWidth'(ByteWidth));
      bytes_step = emit ? bytes_ff + 1'b1 : bytes_ff;

      acc_in   = acc_ff;
      pend_in  = pend_ff;
      if (decode_en && sym.valid && (bytes_ff < ByteLimit)) begin
         if (emit) begin
            pend_in = rest;
            acc_in  = AccWidth'(wide & rest_mask);
         end else begin
            pend_in = PendWidth'(total);
            acc_in  = AccWidth'(wide);
         end
      end
      seen_in  = seen_step;
      bytes_in = bytes_step;
      bad_in   = bad_step;
      // The last character returns the decoder to its reset state.
      if (req_tlast) begin
         acc_in   = '0;
         pend_in  = '0;
         seen_in  = '0;
         bytes_in = '0;
         bad_in   = 1'b0;
      end

      data_res.kind       = KIND_DATA;
      data_res.byte_value = ByteWidth'(wide >> rest);
      data_res.status     = STATUS_OK;
      data_res.byte_count = '0;
      data_res.end_of_run = !req_tlast;

      end_res.kind       = KIND_END;
      end_res.byte_value = '0;
      end_res.byte_count = '0;
      end_res.end_of_run = 1'b1;
      if (seen_step != SeenFull) begin
         end_res.status = STATUS_BAD_LEN;
      end else if (bad_step) begin
         end_res.status = STATUS_BAD_CHAR;
      end else begin
         end_res.status     = STATUS_OK;
         end_res.byte_count = bytes_step;
      end

      first_res = emit ? data_res : end_res;
      push_cnt  = 2'(emit) + 2'(req_tlast);
   end

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      qcnt_in   = qcnt_ff;
      if (req_take) begin
         wr_ptr_in = wr_ptr_ff + PtrWidth'(push_cnt);
         qcnt_in   = qcnt_in + QCntWidth'(push_cnt);
      end
      if (rsp_take) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
         qcnt_in   = qcnt_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         pend_ff   <= '0;
         seen_ff   <= '0;
         bytes_ff  <= '0;
         bad_ff    <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         qcnt_ff   <= '0;
      end else begin
         if (req_take) begin
            acc_ff   <= acc_in;
            pend_ff  <= pend_in;
            seen_ff  <= seen_in;
            bytes_ff <= bytes_in;
            bad_ff   <= bad_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         qcnt_ff   <= qcnt_in;
      end
   end

   // Queue storage: the first result goes to the write pointer, an end item that
   // follows a data byte goes to the slot after it.
   always_ff @(posedge clock) begin
      if (req_take && (push_cnt != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= first_res;
         if (push_cnt == 2'd2) begin
            queue_ff[wr_ptr_ff + 1'b1] <= end_res;
         end
      end
   end

   assign rsp_tvalid = (qcnt_ff != '0);
   assign rsp_tuser  = queue_ff[rd_ptr_ff].kind;
   assign rsp_tlast  = queue_ff[rd_ptr_ff].end_of_run;
   assign rsp_tdata  = {2'b00, queue_ff[rd_ptr_ff].byte_count,
                        queue_ff[rd_ptr_ff].status, queue_ff[rd_ptr_ff].byte_value};

   // The queue never overfills.
   assert property (@(posedge clock) disable iff (reset) qcnt_ff <= QCntWidth'(QueueDepth))
      else $error("result queue count exceeds its depth");

   // The byte counter never passes the per-string limit.
   assert property (@(posedge clock) disable iff (reset) bytes_ff <= ByteLimit)
      else $error("more bytes emitted than the string allows");

   // A last character always leaves the decoder cleared for the next string.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_tlast) |=> (seen_ff == '0 && bytes_ff == '0 && !bad_ff))
      else $error("decoder state not cleared after the last character");

   // Every accepted last character adds at least one queued result.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_tlast && !rsp_take) |=> (qcnt_ff > $past(qcnt_ff)))
      else $error("end item was not queued");

endmodule

// ===== tb/base32hex_fixed_decoder_unit_test.sv =====
// Self-checking testbench for the streaming base32hex fixed-length string decoder.
module base32hex_fixed_decoder_unit_test
   import b32hd_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StringChars = DefStringChars;
   localparam int MaxBytes    = DefMaxBytes;
   localparam int ItemTarget  = 1050;
   localparam int CycleLimit  = 400000;
   localparam int HoldCycles  = 400;
   localparam int DrainCycles = 8;
   localparam int DirectedRows = 25;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [CharWidth-1:0]     req_tdata;
   logic                     req_tlast;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic                     rsp_tuser;
   logic                     rsp_tlast;

   always #1 clock = ~clock;

   base32hex_fixed_decoder_unit #(
      .STRING_CHARS(StringChars),
      .MAX_BYTES   (MaxBytes)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   // Decoder state as the testbench tracks it, one string at a time.
   logic [11:0] acc_bits;
   logic [3:0]  acc_count;
   logic [4:0]  char_total;
   logic [3:0]  byte_total;
   logic        saw_bad_char;

   result_type  step_results[$];    // results of the character just taken
   result_type  decoded_items[$];   // bytes and end items still to arrive

   int mismatches    = 0;
   int chars_sent    = 0;
   int data_seen     = 0;
   int status_tally[3] = '{0, 0, 0};
   int req_gap_max   = 0;
   int rsp_stall_max = 0;
   int long_hold     = 0;
   int cycles        = 0;

   // Directed rows. Rows flagged as typed carry their end status by hand; every such row is a
   // short string, so its byte count is zero and it causes the end item alone.
   typedef struct packed {
      logic [7:0]  code;
      logic        tail;
      logic        typed;
      status_type  status;
   } stim_row_type;

   stim_row_type directed_rows [DirectedRows] = '{
      '{8'h30, 1'b1, 1'b1, STATUS_BAD_LEN},   // "0" alone is a one-character string
      '{8'hFF, 1'b1, 1'b1, STATUS_BAD_LEN},   // top code, invalid and too short
      '{8'h57, 1'b0, 1'b0, STATUS_OK},        // "W" just past the upper-case range
      '{8'h2F, 1'b1, 1'b1, STATUS_BAD_LEN},   // "/" closes it: length beats bad char
      '{8'h00, 1'b1, 1'b1, STATUS_BAD_LEN},   // bottom code
      // A full twenty-character string through the alphabet edges, ending in twelve bytes.
      '{8'h30, 1'b0, 1'b0, STATUS_OK},        // 0
      '{8'h39, 1'b0, 1'b0, STATUS_OK},        // 9
      '{8'h41, 1'b0, 1'b0, STATUS_OK},        // A
      '{8'h56, 1'b0, 1'b0, STATUS_OK},        // V
      '{8'h61, 1'b0, 1'b0, STATUS_OK},        // a
      '{8'h76, 1'b0, 1'b0, STATUS_OK},        // v
      '{8'h30, 1'b0, 1'b0, STATUS_OK},        // 0
      '{8'h56, 1'b0, 1'b0, STATUS_OK},        // V
      '{8'h76, 1'b0, 1'b0, STATUS_OK},        // v
      '{8'h41, 1'b0, 1'b0, STATUS_OK},        // A
      '{8'h61, 1'b0, 1'b0, STATUS_OK},        // a
      '{8'h39, 1'b0, 1'b0, STATUS_OK},        // 9
      '{8'h4B, 1'b0, 1'b0, STATUS_OK},        // K
      '{8'h6B, 1'b0, 1'b0, STATUS_OK},        // k
      '{8'h55, 1'b0, 1'b0, STATUS_OK},        // U
      '{8'h35, 1'b0, 1'b0, STATUS_OK},        // 5
      '{8'h4C, 1'b0, 1'b0, STATUS_OK},        // L
      '{8'h6C, 1'b0, 1'b0, STATUS_OK},        // l
      '{8'h33, 1'b0, 1'b0, STATUS_OK},        // 3
      '{8'h67, 1'b1, 1'b0, STATUS_OK}         // g, last character
   };

   function automatic void clear_decoder_state();
      acc_bits     = '0;
      acc_count    = '0;
      char_total   = '0;
      byte_total   = '0;
      saw_bad_char = 1'b0;
   endfunction

   // Works out what one accepted character yields: at most one byte, then the end item when
   // the character closes the string.
   function automatic void decode_char(input logic [7:0] code, input logic tail);
      logic [7:0]  folded;
      logic [4:0]  sym;
      logic        sym_ok;
      logic [11:0] widened;
      int          total;
      int          rest;
      result_type  item;
      step_results.delete();
      if (char_total < StringChars + 1) char_total++;
      if (!saw_bad_char && char_total <= StringChars) begin
         // Fold lower case onto upper case, then only 0-9 and A-V are symbols.
         folded = (code >= 8'h61 && code <= 8'h7A) ? code - 8'h20 : code;
         sym_ok = 1'b1;
         sym    = '0;
         if (folded >= 8'h30 && folded <= 8'h39) begin
            sym = 5'(folded - 8'h30);
         end else if (folded >= 8'h41 && folded <= 8'h56) begin
            sym = 5'(folded - 8'h41 + 8'd10);
         end else begin
            sym_ok = 1'b0;
         end
         if (!sym_ok) begin
            saw_bad_char = 1'b1;
         end else if (byte_total < MaxBytes) begin
            total   = acc_count + 5;
            widened = {acc_bits[6:0], sym};
            if (total >= 8) begin
               rest            = total - 8;
               item.kind       = KIND_DATA;
               item.byte_value = 8'(widened >> rest);
               item.status     = STATUS_OK;
               item.byte_count = '0;
               item.end_of_run = !tail;
               step_results.push_back(item);
               byte_total++;
               acc_count = 4'(rest);
               acc_bits  = widened & ((12'd1 << rest) - 12'd1);
            end else begin
               acc_count = 4'(total);
               acc_bits  = widened;
            end
         end
      end
      if (tail) begin
         item.kind       = KIND_END;
         item.byte_value = '0;
         item.byte_count = '0;
         item.end_of_run = 1'b1;
         if (char_total != StringChars) begin
            item.status = STATUS_BAD_LEN;
         end else if (saw_bad_char) begin
            item.status = STATUS_BAD_CHAR;
         end else begin
            item.status     = STATUS_OK;
            item.byte_count = byte_total;
         end
         step_results.push_back(item);
         clear_decoder_state();
      end
   endfunction

   // Offers one character after a random gap and records what it should yield once taken.
   task automatic send_char(input logic [7:0] code, input logic tail, input logic typed,
                            input status_type want_status);
      int         gap;
      result_type fixed;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      req_tlast  <= tail;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_char(code, tail);
      if (typed) begin
         fixed.kind       = KIND_END;
         fixed.byte_value = '0;
         fixed.status     = want_status;
         fixed.byte_count = '0;
         fixed.end_of_run = 1'b1;
         decoded_items.push_back(fixed);
      end else begin
         foreach (step_results[i]) decoded_items.push_back(step_results[i]);
      end
      chars_sent++;
   endtask

   function automatic logic [7:0] pick_symbol();
      int v;
      v = $urandom_range(0, 31);
      if (v < 10) return 8'(8'h30 + v);
      if ($urandom_range(0, 1) == 1) return 8'(8'h41 + v - 10);
      return 8'(8'h61 + v - 10);
   endfunction

   // Invalid codes, mostly the neighbors of the alphabet ranges.
   function automatic logic [7:0] pick_invalid();
      case ($urandom_range(0, 8))
         0: return 8'h2F;
         1: return 8'h3A;
         2: return 8'h40;
         3: return 8'h57;
         4: return 8'h60;
         5: return 8'h77;
         6: return 8'h00;
         7: return 8'hFF;
         default: return 8'h7B;
      endcase
   endfunction

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic check_transfer();
      result_type want;
      if (decoded_items.size() == 0) begin
         $error("result with nothing expected: tuser %0b tdata %04h tlast %0b",
                rsp_tuser, rsp_tdata, rsp_tlast);
         mismatches++;
      end else begin
         want = decoded_items.pop_front();
         compare_field("item_kind",  int'(want.kind),       int'(rsp_tuser));
         compare_field("byte_value", int'(want.byte_value), int'(rsp_tdata[7:0]));
         compare_field("status",     int'(want.status),     int'(rsp_tdata[9:8]));
         compare_field("byte_count", int'(want.byte_count), int'(rsp_tdata[13:10]));
         compare_field("end_of_run", int'(want.end_of_run), int'(rsp_tlast));
         if (want.kind == KIND_END) status_tally[want.status]++;
         else data_seen++;
      end
   endtask

   // Result side: a random stall before each transfer, or one long hold-off on request.
   initial begin : result_side
      int stall;
      int taken;
      taken      = 0;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold > 0) begin
            stall     = long_hold;
            long_hold = 0;
         end else begin
            stall = $urandom_range(0, rsp_stall_max);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         check_transfer();
         taken++;
         if (taken % 40 == 0) rsp_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
      end
   end

   initial begin : watchdog
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      int          len;
      int          bad_pos;
      int          shape;
      int          string_idx;
      logic        garbage;
      logic [7:0]  code;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      clear_decoder_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      req_gap_max = 3;
      for (int r = 0; r < DirectedRows; r++) begin
         send_char(directed_rows[r].code, directed_rows[r].tail, directed_rows[r].typed,
                   directed_rows[r].status);
      end

      // Random strings: mostly the right length, the rest short or long; some carry one invalid
      // character, and a few are plain noise over all codes.
      string_idx = 0;
      while (chars_sent < ItemTarget) begin
         shape = $urandom_range(0, 9);
         if (shape <= 5) len = StringChars;
         else if (shape <= 7) len = $urandom_range(1, StringChars - 1);
         else if (shape == 8) len = $urandom_range(StringChars + 1, StringChars + 6);
         else len = $urandom_range(StringChars + 7, 2 * StringChars);
         bad_pos     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
         garbage     = ($urandom_range(0, 14) == 0);
         req_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;

         if (string_idx == 6) begin
            // Hold the result side off while characters keep coming back to back.
            long_hold   = HoldCycles;
            req_gap_max = 0;
            len         = StringChars;
            bad_pos     = -1;
            garbage     = 1'b0;
         end
         if (string_idx % 9 == 8) begin
            // Let everything drain before the next string starts.
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (decoded_items.size() != 0) @(posedge clock);
         end

         for (int i = 0; i < len; i++) begin
            if (garbage) code = 8'($urandom_range(0, 255));
            else if (i == bad_pos) code = pick_invalid();
            else code = pick_symbol();
            send_char(code, (i == len - 1), 1'b0, STATUS_OK);
         end
         string_idx++;
      end
      req_tvalid <= 1'b0;

      while (decoded_items.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d characters; strings closed ok %0d, bad character %0d, wrong length %0d.",
               chars_sent, status_tally[STATUS_OK], status_tally[STATUS_BAD_CHAR],
               status_tally[STATUS_BAD_LEN]);
      $display("Checked %0d data bytes across random gaps, a long result stall and drains.",
               data_seen);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/b32hd_pkg.sv
design/base32hex_fixed_decoder_unit.sv
tb/base32hex_fixed_decoder_unit_test.sv
